// ===== rtl/assert_macros.svh =====
// Assertion macros shared by checker files.
// Clocked on clk, disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/lssr4_pkg.sv =====
// Package for the linear state-space RK4 step unit: types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package lssr4_pkg;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned DT_W   = 16;
  localparam int unsigned DIM    = 4;

  typedef enum logic [1:0] {
    OP_STEP   = 2'd0,
    OP_LOAD_A = 2'd1,
    OP_LOAD_B = 2'd2,
    OP_LOAD_X = 2'd3
  } op_t;

  typedef enum logic {
    REG_MODE = 1'b0,
    REG_DT   = 1'b1
  } reg_idx_t;

  // Stage operand for the state update: the x register added to a scaled f
  typedef enum logic [1:0] {
    SC_HALF  = 2'd0,  // x + dt f / 2
    SC_FULL  = 2'd1,  // x + dt f
    SC_FINAL = 2'd2   // x + dt * weighted / 6
  } scale_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_SAT,
    ST_STAGE,
    ST_SCALE,
    ST_SCALE2,
    ST_ADD,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       clr_acc;   // clear accumulators; when fnum is 0, load operand vector xs from x
    logic       mac_en;    // accumulate one column
    logic [2:0] col;       // column index, 0..7 (A cols then B cols)
    logic       sat_f;     // saturate row sums into f, weight into wsum
    logic [1:0] fnum;      // which derivative (0..3)
    logic       discrete;  // copy f into x directly
    logic       mul_en;    // form f*dt (or wsum*dt) products
    logic       scl_en;    // shift/divide the products
    logic       add_en;    // add to x: into xs or into x
    scale_t     scale;
    logic       clr_flag;
    logic       ld_inc;    // load the divided final increment
  } cmd_t;
endpackage

// ===== rtl/lssr4_datapath.sv =====
// Datapath: matrix/state storage, four MAC lanes, stage arithmetic.
// Depends on lssr4_pkg.
`timescale 1ns / 1ps
module lssr4_datapath import lssr4_pkg::*; #(
  parameter int STATE_SIZE = 4,
  parameter int INPUT_SIZE = 4,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic               load_en,
  input  op_t                load_op,
  input  logic [3:0]         load_idx,
  input  logic signed [31:0] load_val,
  input  logic               u_en,
  input  logic signed [31:0] u_in [DIM],
  input  logic [DT_W-1:0]    dt,
  output logic signed [31:0] x_out [DIM],
  output logic               sat_out
);
  localparam logic signed [63:0] IMAX = 64'sd2147483647;
  localparam logic signed [63:0] IMIN = -64'sd2147483648;
  // ceil(2^36/6): the product shifted by 36 is floor(q/6) or one below it
  localparam logic signed [35:0] RECIP6 = 36'sd11453246123;

  logic signed [31:0] a_r [16];
  logic signed [31:0] b_r [16];
  logic signed [31:0] x_r [DIM];
  logic signed [31:0] xs_r [DIM];
  logic signed [31:0] u_r [DIM];
  logic signed [31:0] f_r [DIM];
  logic signed [34:0] w_r [DIM];
  logic signed [63:0] acc_r [DIM];
  logic signed [63:0] prod_r [DIM];
  logic signed [51:0] wprod_r [DIM];
  logic signed [33:0] inc_r [DIM];
  logic signed [34:0] q_r [DIM];
  logic signed [70:0] m_r [DIM];
  logic sat_r;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > IMAX) return 32'sh7fffffff;
    if (v < IMIN) return 32'sh80000000;
    return v[31:0];
  endfunction
  function automatic logic ovf(input logic signed [63:0] v);
    return (v > IMAX) || (v < IMIN);
  endfunction

  // product column select: A x cols 0..3, B u cols 4..7
  logic signed [31:0] mul_a [DIM];
  logic signed [31:0] mul_b [DIM];
  logic               col_ok;
  logic [1:0]         c2;
  assign c2 = cmd.col[1:0];
  assign col_ok = cmd.col[2] ? (int'(c2) < INPUT_SIZE) : (int'(c2) < STATE_SIZE);

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      if (cmd.col[2]) begin
        mul_a[r] = b_r[4'(r * INPUT_SIZE + int'(c2))];
        mul_b[r] = u_r[c2];
      end else begin
        mul_a[r] = a_r[4'(r * STATE_SIZE + int'(c2))];
        mul_b[r] = xs_r[c2];
      end
    end
  end

  logic signed [63:0] stg_sum [DIM];
  always_comb begin
    for (int r = 0; r < DIM; r++) stg_sum[r] = 64'(x_r[r]) + 64'(inc_r[r]);
  end

  // floor(q/6): estimate from the registered reciprocal product, then one
  // correction step using the remainder, which lies in [0,12)
  logic signed [33:0] k_est [DIM];
  logic signed [36:0] k_rem [DIM];
  logic signed [33:0] kq [DIM];
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      k_est[r] = 34'(m_r[r] >>> 36);
      k_rem[r] = 37'(q_r[r]) - 37'(k_est[r]) * 37'sd6;
      kq[r]    = (k_rem[r] >= 37'sd6) ? k_est[r] + 34'sd1 : k_est[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        a_r[i] <= '0;
        b_r[i] <= '0;
      end
      for (int i = 0; i < DIM; i++) x_r[i] <= '0;
      sat_r <= 1'b0;
    end else begin
      if (load_en) begin
        case (load_op)
          OP_LOAD_A: if (int'(load_idx) < STATE_SIZE * STATE_SIZE) a_r[load_idx] <= load_val;
          OP_LOAD_B: if (int'(load_idx) < STATE_SIZE * INPUT_SIZE) b_r[load_idx] <= load_val;
          OP_LOAD_X: if (int'(load_idx) < STATE_SIZE) x_r[load_idx[1:0]] <= load_val;
          default: ;
        endcase
      end
      if (cmd.clr_flag) sat_r <= 1'b0;
      if (cmd.sat_f) begin
        for (int r = 0; r < DIM; r++) begin
          if (r < STATE_SIZE) begin
            if (ovf(acc_r[r])) sat_r <= 1'b1;
          end
        end
      end
      if (cmd.discrete) begin
        for (int r = 0; r < STATE_SIZE; r++) x_r[r] <= f_r[r];
      end
      if (cmd.add_en) begin
        for (int r = 0; r < STATE_SIZE; r++) begin
          if (ovf(stg_sum[r])) sat_r <= 1'b1;
          if (cmd.scale == SC_FINAL) x_r[r] <= sat32(stg_sum[r]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (u_en) begin
      for (int j = 0; j < DIM; j++) u_r[j] <= (j < INPUT_SIZE) ? u_in[j] : 32'sd0;
    end
    if (cmd.clr_acc) begin
      for (int r = 0; r < DIM; r++) acc_r[r] <= '0;
      if (cmd.fnum == 2'd0) begin
        for (int r = 0; r < DIM; r++) xs_r[r] <= x_r[r];
      end
    end
    if (cmd.mac_en && col_ok) begin
      for (int r = 0; r < DIM; r++)
        acc_r[r] <= acc_r[r] + ((64'(mul_a[r]) * 64'(mul_b[r])) >>> FRAC_BITS);
    end
    if (cmd.sat_f) begin
      for (int r = 0; r < DIM; r++) begin
        f_r[r] <= sat32(acc_r[r]);
        case (cmd.fnum)
          2'd0:    w_r[r] <= 35'(sat32(acc_r[r]));
          2'd3:    w_r[r] <= w_r[r] + 35'(sat32(acc_r[r]));
          default: w_r[r] <= w_r[r] + (35'(sat32(acc_r[r])) <<< 1);
        endcase
      end
    end
    if (cmd.mul_en) begin
      for (int r = 0; r < DIM; r++) begin
        prod_r[r]  <= 64'(f_r[r]) * 64'($signed({1'b0, dt}));
        wprod_r[r] <= 52'(w_r[r]) * 52'($signed({1'b0, dt}));
      end
    end
    if (cmd.scl_en) begin
      for (int r = 0; r < DIM; r++) begin
        case (cmd.scale)
          SC_HALF: inc_r[r] <= 34'(prod_r[r] >>> (DT_W + 1));
          SC_FULL: inc_r[r] <= 34'(prod_r[r] >>> DT_W);
          // floor(wprod/2^16) then floor(/6): two floors compose
          default: q_r[r] <= 35'(wprod_r[r] >>> DT_W);
        endcase
      end
    end
    // reciprocal product registered; correction and load use the registered value
    for (int r = 0; r < DIM; r++) m_r[r] <= 71'(q_r[r]) * 71'(RECIP6);
    if (cmd.ld_inc) begin
      for (int r = 0; r < DIM; r++) inc_r[r] <= kq[r];
    end
    if (cmd.add_en && cmd.scale != SC_FINAL) begin
      for (int r = 0; r < DIM; r++) xs_r[r] <= sat32(stg_sum[r]);
    end
  end

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      x_out[r] = (r < STATE_SIZE) ? x_r[r] : 32'sd0;
    end
  end
  assign sat_out = sat_r;
endmodule

// ===== rtl/lssr4_ctrl.sv =====
// Controller FSM: sequences derivative passes, stage updates and result.
// Depends on lssr4_pkg.
`timescale 1ns / 1ps
module lssr4_ctrl import lssr4_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic go,
  input  logic mode,
  output cmd_t cmd,
  output logic busy,
  output logic done
);
  state_t     st_r, st_nxt;
  logic [2:0] col_r, col_nxt;
  logic [1:0] fn_r, fn_nxt;
  logic [1:0] wt_r, wt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      col_r <= '0;
      fn_r  <= '0;
      wt_r  <= '0;
    end else begin
      st_r  <= st_nxt;
      col_r <= col_nxt;
      fn_r  <= fn_nxt;
      wt_r  <= wt_nxt;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    col_nxt = col_r;
    fn_nxt  = fn_r;
    wt_nxt  = wt_r;
    cmd     = '0;
    cmd.col = col_r;
    cmd.fnum = fn_r;
    cmd.scale = (fn_r == 2'd2) ? SC_FULL : SC_HALF;
    busy = (st_r != ST_IDLE);
    done = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (go) begin
          cmd.clr_acc  = 1'b1;
          cmd.clr_flag = 1'b1;
          cmd.fnum     = 2'd0;
          fn_nxt  = 2'd0;
          col_nxt = '0;
          st_nxt  = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mac_en = 1'b1;
        col_nxt = col_r + 3'd1;
        if (col_r == 3'd7) st_nxt = ST_SAT;
      end
      ST_SAT: begin
        cmd.sat_f = 1'b1;
        if (!mode) st_nxt = ST_STAGE;
        else if (fn_r == 2'd3) st_nxt = ST_SCALE;
        else st_nxt = ST_SCALE;
      end
      ST_STAGE: begin
        // discrete copy
        cmd.discrete = 1'b1;
        st_nxt = ST_DONE;
      end
      ST_SCALE: begin
        cmd.mul_en = 1'b1;
        if (fn_r == 2'd3) cmd.scale = SC_FINAL;
        st_nxt = ST_SCALE2;
        wt_nxt = '0;
      end
      ST_SCALE2: begin
        if (fn_r == 2'd3) begin
          // q, then divide lane, then load increment
          cmd.scale = SC_FINAL;
          wt_nxt = wt_r + 2'd1;
          case (wt_r)
            2'd0: cmd.scl_en = 1'b1;
            2'd1: ;
            default: begin
              cmd.clr_flag = 1'b0;
              st_nxt = ST_ADD;
            end
          endcase
        end else begin
          cmd.scl_en = 1'b1;
          st_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (fn_r == 2'd3) begin
          cmd.scale = SC_FINAL;
          cmd.add_en = 1'b1;
          st_nxt = ST_DONE;
        end else begin
          cmd.add_en = 1'b1;
          st_nxt = ST_MAC;
          fn_nxt = fn_r + 2'd1;
          col_nxt = '0;
        end
      end
      ST_DONE: begin
        done = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    // clear accumulators before each later pass
    if (st_r == ST_ADD && fn_r != 2'd3) begin
      cmd.clr_acc = 1'b1;
      cmd.fnum = fn_r + 2'd1;
    end
  end
endmodule

// ===== rtl/lssr4_fix.sv =====
// Final-increment loader: moves the divided weighted sum into the adder.
// Depends on lssr4_pkg.
`timescale 1ns / 1ps
module lssr4_fix import lssr4_pkg::*; (
  input  cmd_t cmd_in,
  input  logic ld,
  output cmd_t cmd_out
);
  // In the wait cycles of the final scale, load the divided increment
  always_comb begin
    cmd_out = cmd_in;
    if (ld) cmd_out.ld_inc = 1'b1;
  end
endmodule

// ===== rtl/linear_state_space_rk4_step_unit.sv =====
// Top level of the linear state-space RK4 step unit.
// Depends on lssr4_pkg, lssr4_ctrl, lssr4_fix, lssr4_datapath.
//
//  channel | signals                                        | handshake
//  input   | in_op in_entry_index in_entry_value in_u0..u3  | start & !busy
//  result  | out_x0..out_x3 out_saturated                   | out_valid, one cycle
//  config  | cfg_we cfg_index cfg_wdata                     | write on cfg_we
//
// Loads write their target when accepted and leave busy low. A step holds busy until
// its result, shown in the last busy cycle; a new request is taken once busy drops.
// Each derivative pass is an 8-column MAC sweep over four lanes plus saturate.
// Synchronous active-low reset clears A, B, x, sat flag, FSM; sets mode 0, dt 6554.
// The receiver cannot stall; a result is shown for one cycle.
`timescale 1ns / 1ps
module linear_state_space_rk4_step_unit import lssr4_pkg::*; #(
  parameter int STATE_SIZE = 4,
  parameter int INPUT_SIZE = 4,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic [3:0]         in_entry_index,
  input  logic signed [31:0] in_entry_value,
  input  logic signed [31:0] in_u0,
  input  logic signed [31:0] in_u1,
  input  logic signed [31:0] in_u2,
  input  logic signed [31:0] in_u3,
  output logic               out_valid,
  output logic signed [31:0] out_x0,
  output logic signed [31:0] out_x1,
  output logic signed [31:0] out_x2,
  output logic signed [31:0] out_x3,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata
);
  logic            mode_r;
  logic [DT_W-1:0] dt_r;
  logic            acc, go, cbusy, done;
  cmd_t            cmd_c, cmd_d;
  logic signed [31:0] u_v [DIM];
  logic signed [31:0] x_v [DIM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      dt_r   <= 16'd6554;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE: mode_r <= cfg_wdata[0];
        REG_DT:   dt_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign acc = start && !busy;
  assign go  = acc && (op_t'(in_op) == OP_STEP);
  assign busy = cbusy;
  assign u_v[0] = in_u0;
  assign u_v[1] = in_u1;
  assign u_v[2] = in_u2;
  assign u_v[3] = in_u3;

  lssr4_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .go(go), .mode(mode_r),
    .cmd(cmd_c), .busy(cbusy), .done(done)
  );
  lssr4_fix u_fix (
    .cmd_in(cmd_c),
    .ld(cmd_c.scale == SC_FINAL && !cmd_c.mul_en && !cmd_c.scl_en && !cmd_c.add_en
        && cbusy && !cmd_c.mac_en && !cmd_c.sat_f),
    .cmd_out(cmd_d)
  );
  lssr4_datapath #(
    .STATE_SIZE(STATE_SIZE), .INPUT_SIZE(INPUT_SIZE), .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_d),
    .load_en(acc && op_t'(in_op) != OP_STEP), .load_op(op_t'(in_op)),
    .load_idx(in_entry_index), .load_val(in_entry_value),
    .u_en(go), .u_in(u_v), .dt(dt_r),
    .x_out(x_v), .sat_out(out_saturated)
  );

  assign out_valid = done;
  assign out_x0 = x_v[0];
  assign out_x1 = x_v[1];
  assign out_x2 = x_v[2];
  assign out_x3 = x_v[3];
endmodule

// ===== rtl/lssr4_checker.sv =====
// Port-level checker for the RK4 step unit, bound to the top level.
// Depends on assert_macros.svh and lssr4_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lssr4_checker import lssr4_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic [1:0] in_op,
  input logic out_valid
);
  `ASSERT_NEXT(a_step_busy, start && !busy && in_op == OP_STEP, busy)
  `ASSERT_NEXT(a_load_idle, start && !busy && in_op != OP_STEP, !busy && !out_valid)
  `ASSERT_NEXT(a_valid_pulse, out_valid, !out_valid)
  `ASSERT_IMPL(a_valid_busy, out_valid, busy)
endmodule

bind linear_state_space_rk4_step_unit lssr4_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_op(in_op), .out_valid(out_valid)
);
